// ===== hdl/uvsph_pkg.sv =====
package uvsph_pkg;

    localparam int unsigned ANG_W  = 31;
    localparam int unsigned QUO_W  = 33;
    localparam int unsigned CNT_W  = 9;
    localparam int unsigned IDX_W  = 17;
    localparam int unsigned POS_W  = 17;
    localparam int unsigned NRM_W  = 16;
    localparam int unsigned TEX_W  = 17;

    localparam logic [ANG_W-1:0] ONE30 = 31'h4000_0000;

    // Horner coefficients of sin(pi/2 * t), Q30, signs alternate from the top term down
    localparam logic [ANG_W-1:0] SIN_COEF [6] = '{
        31'd1686629713, 31'd693598670, 31'd85569306,
        31'd5026997,    31'd172272,    31'd3864
    };

    typedef enum logic {
        OP_VERTEX   = 1'b0,
        OP_TRIANGLE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_STACKS = 2'd1,
        REG_SLICES = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div;

    typedef struct packed {
        t_opcode          op;
        logic             bad;
        logic             ring_top;
        logic             ring_bot;
        logic             ring_last;
        logic             half;
        logic [CNT_W-1:0] col;
        logic [IDX_W-1:0] base;
    } t_meta;

    typedef struct packed {
        logic [IDX_W-1:0] index_c;
        logic [IDX_W-1:0] index_b;
        logic [IDX_W-1:0] index_a;
        logic [TEX_W-1:0] tex_v;
        logic [TEX_W-1:0] tex_u;
        logic [NRM_W-1:0] norm_z;
        logic [NRM_W-1:0] norm_y;
        logic [NRM_W-1:0] norm_x;
        logic [POS_W-1:0] pos_z;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
    } t_result;

    // one bit of restoring long division; the first step takes the whole numerator
    function automatic t_div div_step(t_div cur, logic [CNT_W-1:0] den, logic first);
        logic [CNT_W:0] trial;
        logic           take;
        t_div           nxt;
        trial    = first ? {1'b0, cur.rem} : {cur.rem, 1'b0};
        take     = (trial >= {1'b0, den});
        nxt.quo  = {cur.quo[QUO_W-2:0], take};
        nxt.rem  = take ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
        return nxt;
    endfunction

    function automatic logic [POS_W-1:0] neg_pos(logic neg, logic [POS_W-1:0] mag);
        return neg ? (~mag + POS_W'(1)) : mag;
    endfunction

    function automatic logic [NRM_W-1:0] neg_nrm(logic neg, logic [NRM_W-1:0] mag);
        return neg ? (~mag + NRM_W'(1)) : mag;
    endfunction

endpackage

// ===== hdl/uv_sphere_mesh_generator.sv =====
// Channel   Dir  Payload (low bit first)                                     Accept
// s_axis    in   tuser: opcode; tdata: ring, column, half, pad               tvalid & tready
// m_axis    out  tdata: pos_x..z, norm_x..z, tex_u, tex_v, index_a..c;      tvalid & tready
//                tuser: bad_request
// cfg       in   i_cfg_addr: register index; i_cfg_wdata: value              i_cfg_we
//
// One request per cycle while the pipe is not held by a stalled output; each result passes
// through the divider, sine polynomial and radius multiply stages, then the output register.
// Angles come from a 33-step divider, up to 4 quotient bits per stage over 9 stages.
// Reset clears the valid bits and loads the default radius and counts.
// A stalled output holds; each stage still fills while it holds a bubble.
module uv_sphere_mesh_generator #(
    parameter int MAX_STACKS = 256,
    parameter int MAX_SLICES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // ring[8:0], column[17:9], half[18], zero pad
    input  logic         s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [183:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                         // tex_u, tex_v, index_a, index_b, index_c
    output logic         m_axis_tuser    // bad_request
);

    localparam int NST    = 21;
    localparam int ST_DV  = 1;
    localparam int ST_DVL = 9;
    localparam int ST_FLD = 10;
    localparam int ST_SQ  = 11;
    localparam int ST_HR  = 12;
    localparam int ST_SIN = 17;
    localparam int ST_M1  = 18;
    localparam int ST_M2  = 19;
    localparam int ST_OUT = 20;
    localparam int DIV_STEPS = 33;
    localparam int STEP_PER  = 4;

    // configuration
    logic [15:0] r_radius;
    logic [8:0]  r_stacks;
    logic [8:0]  r_slices;
    logic [8:0]  cfg_s;
    logic [8:0]  cfg_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd256;
            r_stacks <= 9'd16;
            r_slices <= 9'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                uvsph_pkg::REG_RADIUS: r_radius <= i_cfg_wdata;
                uvsph_pkg::REG_STACKS: r_stacks <= i_cfg_wdata[8:0];
                uvsph_pkg::REG_SLICES: r_slices <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_stacks < 9'd2) begin
            cfg_s = 9'd2;
        end else if (32'(r_stacks) > MAX_STACKS) begin
            cfg_s = 9'(MAX_STACKS);
        end else begin
            cfg_s = r_stacks;
        end
        if (r_slices < 9'd3) begin
            cfg_l = 9'd3;
        end else if (32'(r_slices) > MAX_SLICES) begin
            cfg_l = 9'(MAX_SLICES);
        end else begin
            cfg_l = r_slices;
        end
    end

    // stage handshake: a stage loads when empty or when the next one loads
    logic [NST-1:0] stg_en;
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;

    always_comb begin
        stg_en[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
        for (int k = 0; k < NST; k++) begin
            if (stg_en[k]) begin
                n_vld[k] = (k == 0) ? s_axis_tvalid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = stg_en[0];

    // stage 0: request register
    uvsph_pkg::t_opcode r_op;
    logic [8:0]         r_ring;
    logic [8:0]         r_col;
    logic               r_half;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_op   <= uvsph_pkg::t_opcode'(s_axis_tuser);
            r_ring <= s_axis_tdata[8:0];
            r_col  <= s_axis_tdata[17:9];
            r_half <= s_axis_tdata[18];
        end
    end

    // stage 1 onward: request classification, carried to the output
    uvsph_pkg::t_meta r_meta [ST_DV:ST_M2];
    uvsph_pkg::t_meta n_meta;
    logic [9:0]       row_len;
    logic [8:0]       ring_m1;
    logic [18:0]      row_base;

    always_comb begin
        row_len  = {1'b0, cfg_l} + 10'd1;
        ring_m1  = r_ring - 9'd1;
        row_base = 19'(ring_m1) * 19'(row_len) + 19'd1;
        n_meta.op        = r_op;
        n_meta.ring_top  = (r_ring == 9'd0);
        n_meta.ring_bot  = (r_ring == cfg_s);
        n_meta.ring_last = (r_ring == cfg_s - 9'd1);
        n_meta.half      = r_half;
        n_meta.col       = r_col;
        n_meta.base      = row_base[16:0];
        if (r_op == uvsph_pkg::OP_VERTEX) begin
            n_meta.bad = (r_ring > cfg_s) || (r_col > cfg_l);
        end else begin
            n_meta.bad = (r_ring >= cfg_s) || (r_col >= cfg_l);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_DV]) begin
            r_meta[ST_DV] <= n_meta;
        end
    end

    genvar g, ln;
    generate
        for (g = ST_DV + 1; g <= ST_M2; g++) begin : g_meta
            always_ff @(posedge i_clk) begin
                if (stg_en[g]) begin
                    r_meta[g] <= r_meta[g-1];
                end
            end
        end
    endgenerate

    // stages 1..9: ring*2^32/S and column*2^32/L, up to four quotient bits per stage
    uvsph_pkg::t_div r_dv_r [ST_DV:ST_DVL];
    uvsph_pkg::t_div r_dv_c [ST_DV:ST_DVL];
    uvsph_pkg::t_div w_dv_r [0:ST_DVL];
    uvsph_pkg::t_div w_dv_c [0:ST_DVL];

    assign w_dv_r[0] = '{rem: r_ring, quo: '0};
    assign w_dv_c[0] = '{rem: r_col,  quo: '0};

    generate
        for (g = ST_DV; g <= ST_DVL; g++) begin : g_div
            uvsph_pkg::t_div nr;
            uvsph_pkg::t_div nc;
            assign w_dv_r[g] = r_dv_r[g];
            assign w_dv_c[g] = r_dv_c[g];
            always_comb begin
                nr = w_dv_r[g-1];
                nc = w_dv_c[g-1];
                for (int j = 0; j < STEP_PER; j++) begin
                    if ((g - 1) * STEP_PER + j < DIV_STEPS) begin
                        nr = uvsph_pkg::div_step(nr, cfg_s, ((g - 1) * STEP_PER + j) == 0);
                        nc = uvsph_pkg::div_step(nc, cfg_l, ((g - 1) * STEP_PER + j) == 0);
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (stg_en[g]) begin
                    r_dv_r[g] <= nr;
                    r_dv_c[g] <= nc;
                end
            end
        end
    endgenerate

    // stage 10: quadrant fold and texture coordinates
    logic [30:0] r_pt   [ST_FLD:ST_SIN-1][4];
    logic [3:0]  r_neg  [ST_FLD:ST_M2];
    logic [16:0] r_tex_u [ST_FLD:ST_M2];
    logic [16:0] r_tex_v [ST_FLD:ST_M2];
    logic [31:0] ang [4];
    logic [30:0] n_t [4];
    logic [3:0]  n_neg;
    logic [33:0] tu_sum;
    logic [33:0] tv_sum;

    always_comb begin
        ang[0] = r_dv_r[ST_DVL].quo[32:1];
        ang[1] = r_dv_r[ST_DVL].quo[32:1] + 32'h4000_0000;
        ang[2] = r_dv_c[ST_DVL].quo[31:0];
        ang[3] = r_dv_c[ST_DVL].quo[31:0] + 32'h4000_0000;
        for (int l = 0; l < 4; l++) begin
            n_t[l]   = ang[l][30] ? (uvsph_pkg::ONE30 - {1'b0, ang[l][29:0]})
                                  : {1'b0, ang[l][29:0]};
            n_neg[l] = ang[l][31];
        end
        // round half up from the 16-bit-finer quotient
        tu_sum = {1'b0, r_dv_c[ST_DVL].quo} + 34'h8000;
        tv_sum = {1'b0, r_dv_r[ST_DVL].quo} + 34'h8000;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_FLD]) begin
            r_pt[ST_FLD]    <= n_t;
            r_neg[ST_FLD]   <= n_neg;
            r_tex_u[ST_FLD] <= tu_sum[32:16];
            r_tex_v[ST_FLD] <= tv_sum[32:16];
        end
    end

    generate
        for (g = ST_FLD + 1; g <= ST_M2; g++) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (stg_en[g]) begin
                    r_neg[g]   <= r_neg[g-1];
                    r_tex_u[g] <= r_tex_u[g-1];
                    r_tex_v[g] <= r_tex_v[g-1];
                end
            end
        end
        for (g = ST_FLD + 1; g <= ST_SIN - 1; g++) begin : g_tcarry
            always_ff @(posedge i_clk) begin
                if (stg_en[g]) begin
                    r_pt[g] <= r_pt[g-1];
                end
            end
        end
    endgenerate

    // stage 11: t squared; stages 12..16: Horner steps; stage 17: times t, clamp
    logic [30:0] r_pt2 [ST_SQ:ST_SIN-2][4];
    logic [30:0] r_acc [ST_HR:ST_SIN-1][4];
    logic [30:0] r_sin [4];

    generate
        for (ln = 0; ln < 4; ln++) begin : g_lane
            logic [61:0] sq;
            logic [61:0] fin;
            logic [31:0] fin_q;
            assign sq    = 62'(r_pt[ST_FLD][ln]) * 62'(r_pt[ST_FLD][ln]);
            assign fin   = 62'(r_acc[ST_SIN-1][ln]) * 62'(r_pt[ST_SIN-1][ln]);
            assign fin_q = fin[61:30];
            always_ff @(posedge i_clk) begin
                if (stg_en[ST_SQ]) begin
                    r_pt2[ST_SQ][ln] <= sq[60:30];
                end
                if (stg_en[ST_SIN]) begin
                    r_sin[ln] <= (fin_q > 32'(uvsph_pkg::ONE30)) ? uvsph_pkg::ONE30
                                                                  : fin_q[30:0];
                end
            end
            for (g = ST_SQ + 1; g <= ST_SIN - 2; g++) begin : g_t2
                always_ff @(posedge i_clk) begin
                    if (stg_en[g]) begin
                        r_pt2[g][ln] <= r_pt2[g-1][ln];
                    end
                end
            end
            for (g = ST_HR; g <= ST_SIN - 1; g++) begin : g_horner
                logic [30:0] prev;
                logic [61:0] prod;
                logic [31:0] diff;
                if (g == ST_HR) begin : g_first
                    assign prev = uvsph_pkg::SIN_COEF[5];
                end else begin : g_next
                    assign prev = r_acc[g-1][ln];
                end
                assign prod = 62'(prev) * 62'(r_pt2[g-1][ln]);
                assign diff = 32'(uvsph_pkg::SIN_COEF[ST_SIN - 1 - g]) - prod[61:30];
                always_ff @(posedge i_clk) begin
                    if (stg_en[g]) begin
                        r_acc[g][ln] <= diff[30:0];
                    end
                end
            end
        end
    endgenerate

    // stage 18: direction products and radius times cos phi
    logic [61:0] r_mx;
    logic [61:0] r_mz;
    logic [46:0] r_pcy;
    logic [30:0] r_cp;

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_M1]) begin
            r_mx  <= 62'(r_sin[0]) * 62'(r_sin[3]);
            r_mz  <= 62'(r_sin[0]) * 62'(r_sin[2]);
            r_pcy <= 47'(r_radius) * 47'(r_sin[1]);
            r_cp  <= r_sin[1];
        end
    end

    // stage 19: round to Q30, scale by radius, normals to Q1.14
    logic [61:0] mx_rnd;
    logic [61:0] mz_rnd;
    logic [61:0] mx_nrm;
    logic [61:0] mz_nrm;
    logic [46:0] py_rnd;
    logic [30:0] cp_rnd;
    logic [46:0] r_px;
    logic [46:0] r_pz;
    logic [16:0] r_py;
    logic [15:0] r_nx;
    logic [15:0] r_ny;
    logic [15:0] r_nz;

    always_comb begin
        mx_rnd = r_mx + 62'h2000_0000;
        mz_rnd = r_mz + 62'h2000_0000;
        mx_nrm = r_mx + (62'd1 << 45);
        mz_nrm = r_mz + (62'd1 << 45);
        py_rnd = r_pcy + 47'h2000_0000;
        cp_rnd = r_cp + 31'h8000;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_M2]) begin
            r_px <= 47'(r_radius) * 47'(mx_rnd[60:30]);
            r_pz <= 47'(r_radius) * 47'(mz_rnd[60:30]);
            r_py <= py_rnd[46:30];
            r_nx <= mx_nrm[61:46];
            r_nz <= mz_nrm[61:46];
            r_ny <= {1'b0, cp_rnd[30:16]};
        end
    end

    // stage 20: select, sign and register the result
    uvsph_pkg::t_meta   mo;
    uvsph_pkg::t_result n_res;
    uvsph_pkg::t_result r_res;
    logic               r_bad;
    logic [46:0]        px_rnd;
    logic [46:0]        pz_rnd;
    logic               sx;
    logic               sz;
    logic [16:0]        rlen;
    logic [16:0]        up;
    logic [16:0]        dn;

    always_comb begin
        mo     = r_meta[ST_M2];
        px_rnd = r_px + 47'h2000_0000;
        pz_rnd = r_pz + 47'h2000_0000;
        sx     = r_neg[ST_M2][0] ^ r_neg[ST_M2][3];
        sz     = r_neg[ST_M2][0] ^ r_neg[ST_M2][2];
        rlen   = 17'(cfg_l) + 17'd1;
        up     = mo.base + 17'(mo.col);
        dn     = up + rlen;
        n_res  = '0;
        if (mo.bad) begin
            n_res = '0;
        end else if (mo.op == uvsph_pkg::OP_VERTEX) begin
            if (mo.ring_top || mo.ring_bot) begin
                n_res.pos_y  = uvsph_pkg::neg_pos(mo.ring_bot, {1'b0, r_radius});
                n_res.norm_y = uvsph_pkg::neg_nrm(mo.ring_bot, 16'd16384);
                n_res.tex_v  = mo.ring_bot ? 17'h10000 : 17'd0;
            end else begin
                n_res.pos_x  = uvsph_pkg::neg_pos(sx, px_rnd[46:30]);
                n_res.pos_y  = uvsph_pkg::neg_pos(r_neg[ST_M2][1], r_py);
                n_res.pos_z  = uvsph_pkg::neg_pos(sz, pz_rnd[46:30]);
                n_res.norm_x = uvsph_pkg::neg_nrm(sx, r_nx);
                n_res.norm_y = uvsph_pkg::neg_nrm(r_neg[ST_M2][1], r_ny);
                n_res.norm_z = uvsph_pkg::neg_nrm(sz, r_nz);
                n_res.tex_u  = r_tex_u[ST_M2];
                n_res.tex_v  = r_tex_v[ST_M2];
            end
        end else if (mo.ring_top) begin
            n_res.index_a = '0;
            n_res.index_b = 17'(mo.col) + 17'd2;
            n_res.index_c = 17'(mo.col) + 17'd1;
        end else if (mo.ring_last) begin
            n_res.index_a = mo.base + rlen;
            n_res.index_b = up;
            n_res.index_c = up + 17'd1;
        end else if (!mo.half) begin
            n_res.index_a = up;
            n_res.index_b = up + 17'd1;
            n_res.index_c = dn;
        end else begin
            n_res.index_a = dn;
            n_res.index_b = up + 17'd1;
            n_res.index_c = dn + 17'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_OUT]) begin
            r_res <= n_res;
            r_bad <= mo.bad;
        end
    end

    assign m_axis_tvalid = r_vld[ST_OUT];
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = r_bad;

    // an empty output register lets the whole pipe advance
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[ST_OUT] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad request carries nonzero fields");

    a_tri_no_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_res.index_a != '0 || r_res.index_b != '0)
            |-> m_axis_tdata[132:0] == '0)
        else $error("triangle result carries vertex fields");

endmodule
